// ===== sv/ntew_pkg.sv =====
// ----------------------------------------------------------------------------
// ntew_pkg
// Shared types and constants for the number-to-word-token block.
// ----------------------------------------------------------------------------
package ntew_pkg;

  // Binary input, padded to a whole number of conversion steps
  localparam int NUMBER_W   = 31;
  localparam int BIN_W      = 32;
  localparam int STEP_BITS  = 4;
  localparam int NUM_STAGES = BIN_W / STEP_BITS;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;

  localparam int WORD_W     = 5;
  // Five word slots per group, four for the units group (no scale word)
  localparam int GRP_SLOTS  = 5;
  localparam int NUM_SLOTS  = 3 * GRP_SLOTS + (GRP_SLOTS - 1);

  // Word codes
  localparam logic [WORD_W-1:0] W_ZERO      = 5'd0;
  localparam logic [WORD_W-1:0] W_TEEN_BASE = 5'd10;
  localparam logic [WORD_W-1:0] W_TENS_BASE = 5'd18;
  localparam logic [WORD_W-1:0] W_HUNDRED   = 5'd28;
  localparam logic [WORD_W-1:0] W_THOUSAND  = 5'd29;
  localparam logic [WORD_W-1:0] W_MILLION   = 5'd30;
  localparam logic [WORD_W-1:0] W_BILLION   = 5'd31;

  // One classified number: which word slots speak, and what they say.
  // Slot NUM_SLOTS-1 is the most significant word.
  typedef struct packed {
    logic [NUM_SLOTS-1:0]             mask;
    logic [NUM_SLOTS-1:0][WORD_W-1:0] words;
  } ntew_entry_t;

endpackage

// ===== sv/ntew_front.sv =====
// ----------------------------------------------------------------------------
// ntew_front
// Binary to BCD pipeline (four double-dabble steps per stage) followed by
// classification of each three-digit group into word slots.
// ----------------------------------------------------------------------------
module ntew_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [30:0]               in_number,
  output logic                      push_valid,
  input  logic                      push_ready,
  output ntew_pkg::ntew_entry_t     push_data
);
  import ntew_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  typedef struct packed {
    logic [GRP_SLOTS-1:0]             mask;
    logic [GRP_SLOTS-1:0][WORD_W-1:0] words;
  } grp_t;

  logic [NUM_STAGES-1:0]                   v_r;
  logic [NUM_STAGES-1:0][BIN_W-1:0]        bin_r;
  logic [NUM_STAGES-1:0][BCD_W-1:0]        bcd_r;
  logic [NUM_STAGES-1:0][BCD_W+BIN_W-1:0]  dab;
  logic                                    adv;
  logic [BCD_W-1:0]                        bcd_fin;
  logic                                    bcd_ok;
  grp_t                                    g3, g2, g1, g0;

  // Four shift-add-3 steps
  function automatic logic [BCD_W+BIN_W-1:0] dabble(
    input logic [BCD_W-1:0] bcd_i,
    input logic [BIN_W-1:0] bin_i
  );
    logic [BCD_W+BIN_W-1:0] acc;
    acc = {bcd_i, bin_i};
    for (int j = 0; j < STEP_BITS; j++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (acc[BIN_W+4*d +: 4] >= 4'd5) begin
          acc[BIN_W+4*d +: 4] = acc[BIN_W+4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[BCD_W+BIN_W-2:0], 1'b0};
    end
    return acc;
  endfunction

  // Slots: [4] digit, [3] Hundred, [2] unit/teen/tens, [1] unit, [0] scale
  function automatic grp_t classify(
    input logic [3:0]        h,
    input logic [3:0]        t,
    input logic [3:0]        u,
    input logic [WORD_W-1:0] scale
  );
    grp_t g;
    g.words[4] = {1'b0, h};
    g.words[3] = W_HUNDRED;
    if (t == 4'd0) begin
      g.words[2] = {1'b0, u};
    end else if (t == 4'd1) begin
      g.words[2] = W_TEEN_BASE + {1'b0, u};
    end else begin
      g.words[2] = W_TENS_BASE + {1'b0, t};
    end
    g.words[1] = {1'b0, u};
    g.words[0] = scale;
    g.mask[4]  = (h != 4'd0);
    g.mask[3]  = (h != 4'd0);
    g.mask[2]  = (t != 4'd0) || (u != 4'd0);
    g.mask[1]  = (t >= 4'd2) && (u != 4'd0);
    g.mask[0]  = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
    return g;
  endfunction

  always_comb begin
    dab[0] = dabble('0, {1'b0, in_number});
    for (int s = 1; s < NUM_STAGES; s++) begin
      dab[s] = dabble(bcd_r[s-1], bin_r[s-1]);
    end
  end

  // Whole pipe holds while the last stage cannot hand off
  assign adv      = !v_r[LAST] || push_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        {bcd_r[s], bin_r[s]} <= dab[s];
      end
    end
  end

  assign bcd_fin = bcd_r[LAST];

  always_comb begin
    g3 = classify(4'd0, 4'd0, bcd_fin[39:36], W_BILLION);
    g2 = classify(bcd_fin[35:32], bcd_fin[31:28], bcd_fin[27:24], W_MILLION);
    g1 = classify(bcd_fin[23:20], bcd_fin[19:16], bcd_fin[15:12], W_THOUSAND);
    g0 = classify(bcd_fin[11:8], bcd_fin[7:4], bcd_fin[3:0], W_ZERO);
  end

  always_comb begin
    push_data.mask  = {g3.mask, g2.mask, g1.mask, g0.mask[GRP_SLOTS-1:1]};
    push_data.words = {g3.words, g2.words, g1.words, g0.words[GRP_SLOTS-1:1]};
    // Zero spells as the lone word Zero, from the units teen/tens slot
    if (bcd_fin == '0) begin
      push_data.mask[1] = 1'b1;
    end
  end

  assign push_valid = v_r[LAST];

  always_comb begin
    bcd_ok = 1'b1;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_fin[4*d +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] |-> bcd_ok)
    else $error("ntew_front: converted digit out of decimal range");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[LAST] && !push_ready) |=> (v_r[LAST] && $stable(bcd_r[LAST])))
    else $error("ntew_front: stalled item lost in last stage");

endmodule

// ===== sv/ntew_queue.sv =====
// ----------------------------------------------------------------------------
// ntew_queue
// Small FIFO of classified items between conversion and word emission.
// ----------------------------------------------------------------------------
module ntew_queue #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_valid,
  output logic                      push_ready,
  input  ntew_pkg::ntew_entry_t     push_data,
  output logic                      pop_valid,
  input  logic                      pop_ready,
  output ntew_pkg::ntew_entry_t     pop_data
);
  import ntew_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  ntew_entry_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 do_push, do_pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("ntew_queue: occupancy beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("ntew_queue: pointers disagree on empty queue");

endmodule

// ===== sv/ntew_back.sv =====
// ----------------------------------------------------------------------------
// ntew_back
// Walks the active word slots of one item, most significant first, one
// word per accepted output, and flags the final word.
// ----------------------------------------------------------------------------
module ntew_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  ntew_pkg::ntew_entry_t     pop_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [4:0]                out_word,
  output logic                      out_last
);
  import ntew_pkg::*;

  logic [NUM_SLOTS-1:0]             mask_r, mask_nxt;
  logic [NUM_SLOTS-1:0][WORD_W-1:0] words_r;
  logic [NUM_SLOTS-1:0]             sel;
  logic [NUM_SLOTS-1:0]             rest;
  logic                             found;
  logic                             fire;

  // Highest pending slot
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i] && !found) begin
        sel[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  always_comb begin
    out_word = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) begin
        out_word = out_word | words_r[i];
      end
    end
  end

  assign rest      = mask_r & ~sel;
  assign out_valid = (mask_r != '0);
  assign out_last  = (rest == '0);
  assign fire      = out_valid && out_ready;
  // Next item loads as the final word of this one leaves
  assign pop_ready = !out_valid || (out_ready && out_last);

  always_comb begin
    mask_nxt = mask_r;
    if (pop_ready) begin
      mask_nxt = pop_valid ? pop_data.mask : '0;
    end else if (fire) begin
      mask_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      words_r <= pop_data.words;
    end
  end

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |-> (pop_data.mask != '0))
    else $error("ntew_back: item with no words");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(sel))
    else $error("ntew_back: slot select not one-hot");

endmodule

// ===== sv/number_to_english_word_tokens.sv =====
// ----------------------------------------------------------------------------
// number_to_english_word_tokens
// Spells a 31-bit unsigned integer as a run of English word codes.
// ----------------------------------------------------------------------------
// Each accepted in_number comes out as 1 to 16 word codes on out_word, most
// significant word first, with out_last high on the final one (Zero spells
// as the single word 0; 2147483647 is the longest run, 16 words). The input
// side is an 8-stage binary-to-BCD pipeline (4 bits per stage) that accepts
// one number per cycle while it is not backed up; classified numbers wait in
// a QUEUE_DEPTH-entry queue. The output side delivers one word per cycle
// while out_ready is high, and an item holds the output until all its words
// are taken before the next item loads. A number passes the pipeline stages,
// the queue and the word slot register before its first word appears. Items
// queued behind each other leave without gaps between their runs.
// ----------------------------------------------------------------------------
module number_to_english_word_tokens #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_word,
  output logic        out_last
);
  import ntew_pkg::*;

  // front -> queue
  logic        fq_valid, fq_ready;
  ntew_entry_t fq_data;
  // queue -> back
  logic        qb_valid, qb_ready;
  ntew_entry_t qb_data;

  // Conversion and classification into word slots
  ntew_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_number  (in_number),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data)
  );

  // Decouples conversion stalls from the word emitter
  ntew_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // One word per output handshake
  ntew_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .out_last  (out_last)
  );

endmodule

// ===== tb/ntew_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntew_checker
// Watches both channels of the number-to-word-token block, predicts the word
// run of every accepted number and checks each accepted word in order.
// ----------------------------------------------------------------------------
module ntew_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ntew_pkg::NUMBER_W-1:0] in_number,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ntew_pkg::WORD_W-1:0]   out_word,
  input  logic                          out_last,
  output int                            errors,
  output int                            words_pending,
  output int                            numbers_seen,
  output int                            words_seen
);
  import ntew_pkg::*;

  typedef struct {
    logic [NUMBER_W-1:0] number;
    logic [WORD_W-1:0]   word;
    logic                last;
  } spelled_word_t;

  spelled_word_t spelled_q[$];

  // Append the English spelling of n to the queue of words still owed
  function automatic void spell_number(input logic [NUMBER_W-1:0] n);
    int unsigned       v;
    int unsigned       grp [4];
    int unsigned       hund;
    int unsigned       rest;
    logic [WORD_W-1:0] scale [4];
    logic [WORD_W-1:0] run [$];
    spelled_word_t     tok;
    v     = n;
    scale = '{W_ZERO, W_THOUSAND, W_MILLION, W_BILLION};
    if (v == 0) begin
      run.push_back(W_ZERO);
    end else begin
      grp[0] = v % 1000;
      grp[1] = (v / 1000) % 1000;
      grp[2] = (v / 1000000) % 1000;
      grp[3] = v / 1000000000;
      for (int i = 3; i >= 0; i--) begin
        if (grp[i] != 0) begin
          hund = grp[i] / 100;
          rest = grp[i] % 100;
          if (hund != 0) begin
            run.push_back(WORD_W'(hund));
            run.push_back(W_HUNDRED);
          end
          if (rest != 0 && rest < 20) begin
            run.push_back(WORD_W'(rest));
          end else if (rest >= 20) begin
            run.push_back(W_TENS_BASE + WORD_W'(rest / 10));
            if (rest % 10 != 0) run.push_back(WORD_W'(rest % 10));
          end
          // units group carries no scale word
          if (i > 0) run.push_back(scale[i]);
        end
      end
    end
    foreach (run[k]) begin
      tok.number = n;
      tok.word   = run[k];
      tok.last   = (k == run.size() - 1);
      spelled_q.push_back(tok);
    end
  endfunction

  task automatic note_failure(input string what, input spelled_word_t exp_tok);
    errors++;
    if (errors <= 10)
      $display("%0t ERROR %s: number %0d expected word %0d last %0b, got word %0d last %0b",
               $realtime, what, exp_tok.number, exp_tok.word, exp_tok.last,
               out_word, out_last);
  endtask

  always @(posedge clk) begin
    spelled_word_t exp_tok;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        spell_number(in_number);
        numbers_seen++;
      end
      if (out_valid && out_ready) begin
        words_seen++;
        if (spelled_q.size() == 0) begin
          exp_tok = '{number: '0, word: 'x, last: 'x};
          note_failure("unexpected word", exp_tok);
        end else begin
          exp_tok = spelled_q.pop_front();
          if (out_word !== exp_tok.word || out_last !== exp_tok.last)
            note_failure("word mismatch", exp_tok);
        end
      end
    end
    words_pending <= spelled_q.size();
  end

endmodule

// ===== tb/tb_number_to_english_word_tokens.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_number_to_english_word_tokens
// Stimulus and verdict for the number-to-word-token block.
// ----------------------------------------------------------------------------
// A directed list of numbers covers zero, teens, tens boundaries, hundreds,
// skipped zero groups, every scale word and the widest run. Random numbers
// follow, drawn from several shapes so that short and long runs both occur.
// Sender and receiver idle at random, the sender before each number and the
// receiver before each word, with one stretch of back-to-back traffic and
// one long receiver hold-off that backs the block up until in_ready drops.
// ntew_checker predicts and compares; this module only drives and reports.
// ----------------------------------------------------------------------------
module tb_number_to_english_word_tokens;
  import ntew_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int DRAIN_CYCLES = 40;       // lets stray output show up after the last owed word
  localparam int LIMIT_CYCLES = 400000;   // watchdog limit on the whole run
  localparam logic [NUMBER_W-1:0] NUM_MAX = {NUMBER_W{1'b1}};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [NUMBER_W-1:0] in_number = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [WORD_W-1:0]   out_word;
  logic                out_last;

  int errors;
  int words_pending;
  int numbers_seen;
  int words_seen;

  int  cycle_count  = 0;
  int  in_stall_cyc = 0;   // cycles the block refused an offered number
  bit  no_gaps      = 1'b0;  // both sides run back to back
  bit  hold_req     = 1'b0;  // asks the receiver for a long hold-off

  always #(HALF_PERIOD) clk = ~clk;

  number_to_english_word_tokens u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_number (in_number),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .out_last  (out_last)
  );

  ntew_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .out_last      (out_last),
    .errors        (errors),
    .words_pending (words_pending),
    .numbers_seen  (numbers_seen),
    .words_seen    (words_seen)
  );

  // Watchdog, plus a count of cycles the input side was backed up
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_valid && !in_ready) in_stall_cyc++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count, words_pending);
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one number: optional idle gap, then hold valid until taken.
  // Valid stays high across back-to-back items, so it is never dropped and
  // raised within the same falling edge.
  task automatic send_number(input logic [NUMBER_W-1:0] n);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_number <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random numbers of several shapes; plain uniform draws would almost
  // always land in the billions and give long runs only.
  function automatic logic [NUMBER_W-1:0] pick_number();
    longint unsigned v;
    int unsigned     g;
    v = 0;
    case ($urandom_range(0, 5))
      0: v = $urandom() & NUM_MAX;
      1: v = $urandom_range(0, 999);
      2: v = $urandom_range(0, 999999);
      3: begin
        // Assemble group by group, billions first, with zero, teen, round
        // and full groups
        for (int i = 0; i < 4; i++) begin
          case ($urandom_range(0, 4))
            0: g = 0;
            1: g = $urandom_range(1, 19);
            2: g = 100 * $urandom_range(1, 9);
            3: g = 10 * $urandom_range(2, 9) + 100 * $urandom_range(0, 9);
            default: g = $urandom_range(0, 999);
          endcase
          if (i == 0) g = g % 3;
          v = v * 1000 + g;
        end
      end
      4: v = (64'd1 << $urandom_range(0, 30)) + $urandom_range(0, 3) - 1;
      default: v = NUM_MAX - $urandom_range(0, 200000);
    endcase
    return v[NUMBER_W-1:0];
  endfunction

  // Receiver: a random idle gap before each word; one long hold-off on request
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [NUMBER_W-1:0] directed [$];
    int drain;
    // zero, single words, tens edges, hundreds, skipped groups, every scale,
    // all-ones (widest run) and single high bit
    directed = '{31'd0, 31'd1, 31'd7, 31'd19, 31'd20, 31'd21, 31'd99, 31'd100,
                 31'd101, 31'd110, 31'd119, 31'd120, 31'd999, 31'd1000,
                 31'd1001, 31'd100000, 31'd1000000, 31'd1010010,
                 31'd999999999, 31'd1000000000, 31'd1234567891,
                 31'd2000000010, 31'd1073741824, NUM_MAX};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) send_number(directed[k]);

    // random traffic with idling on both sides
    repeat (150) send_number(pick_number());

    // receiver stops for a long stretch while numbers keep coming, so the
    // pipeline and queue fill and in_ready drops
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_number(pick_number());

    // back to back on both sides
    repeat (60) send_number(pick_number());
    no_gaps = 1'b0;

    repeat (110) send_number(pick_number());
    @(negedge clk);
    in_valid <= 1'b0;

    // wait for every owed word, then let stray output show up
    while (words_pending != 0) @(negedge clk);
    drain = DRAIN_CYCLES;
    repeat (drain) @(negedge clk);

    $display("summary: %0d numbers spelled, %0d words checked, %0d mismatches",
             numbers_seen, words_seen, errors);
    $display("summary: input backed up for %0d cycles, one %0d-cycle output hold-off",
             in_stall_cyc, HOLD_CYCLES);
    if (errors == 0 && words_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
